FILE: rtl/core/irt_pkg.sv
// Shared types and constants for the interval reservation table.
package irt_pkg;

  localparam int FIELD_BITS          = 32;
  localparam int DEFAULT_TABLE_DEPTH = 64;
  localparam int DEFAULT_TIME_BITS   = 32;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [FIELD_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OUT_GRANTED   = 2'd0,
    OUT_OVERLAP   = 2'd1,
    OUT_FULL      = 2'd2,
    OUT_MALFORMED = 2'd3
  } outcome_t;

  // Classified request handed from the front to the back
  typedef struct packed {
    logic [FIELD_BITS-1:0] number;
    logic [FIELD_BITS-1:0] lo;
    logic [FIELD_BITS-1:0] hi;
    logic                  malformed;
  } req_t;

endpackage

FILE: rtl/core/interval_reservation_table_top.sv
// Top level of the interval reservation table.
//
// Usage: each request on the slave stream asks to reserve the closed interval
// [lo_time, hi_time]. The block answers every request with exactly one
// result on the master stream: the request's sequence number (from 1 after
// reset, saturating at all ones), a grant flag and an outcome code (granted,
// overlaps a stored interval, table full, start after finish). A granted
// interval is appended to the table; touching endpoints count as overlap.
// Flow: the front end numbers and checks a request in the accept cycle and
// parks it in a two-entry queue. The table engine then reads the stored
// intervals one per cycle through a single memory read port and a shared
// comparator, finishing one request before it takes the next from the queue;
// a full table, a malformed request or an empty table skips the scan, and a
// clash ends the scan early. The scan sets the sustained rate.
//
// Reset (rst, synchronous) empties the table, the queue and the result
// register and restarts numbering. The table needs no clearing pass. When the
// receiver stalls, the result holds in the output register, the engine waits,
// and the queue still takes up to two more requests before tready drops.
module interval_reservation_table_top #(
  parameter int TABLE_DEPTH = irt_pkg::DEFAULT_TABLE_DEPTH,
  parameter int TIME_BITS   = irt_pkg::DEFAULT_TIME_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] lo_time, [63:32] hi_time
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] request_number, [33:32] outcome, [39:34] zero
  output logic        m_tuser    // [0] granted
);
  import irt_pkg::*;

  req_t                  push_item;
  req_t                  head_item;
  logic                  push;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic [FIELD_BITS-1:0] out_number;
  outcome_t              out_outcome;

  // Number, mask and classify each request as it is accepted
  irt_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  // Decouple acceptance from the table scan
  irt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  // Scan the table, insert on grant, hold the result for the receiver
  irt_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (head_item),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_number  (out_number),
    .out_granted (m_tuser),
    .out_outcome (out_outcome)
  );

  assign m_tdata = {6'b0, out_outcome, out_number};

endmodule

FILE: rtl/core/irt_front.sv
// Request front end: numbering, time masking and well-formedness check.
module irt_front #(
  parameter int TIME_BITS = irt_pkg::DEFAULT_TIME_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [2*irt_pkg::FIELD_BITS-1:0] s_tdata,
  output logic                             push,
  output irt_pkg::req_t                    push_item,
  input  logic                             q_full
);
  import irt_pkg::*;

  localparam logic [FIELD_BITS-1:0] TIME_MASK =
    (TIME_BITS >= FIELD_BITS) ? {FIELD_BITS{1'b1}}
                              : FIELD_BITS'((64'd1 << TIME_BITS) - 64'd1);

  logic [FIELD_BITS-1:0] counter;
  logic [FIELD_BITS-1:0] counter_next;
  logic [FIELD_BITS-1:0] lo;
  logic [FIELD_BITS-1:0] hi;

  assign s_tready     = !q_full;
  assign push         = s_tvalid && s_tready;
  assign lo           = s_tdata[FIELD_BITS-1:0] & TIME_MASK;
  assign hi           = s_tdata[2*FIELD_BITS-1:FIELD_BITS] & TIME_MASK;
  // saturate at the top count
  assign counter_next = (counter == COUNT_MAX) ? counter : counter + 1'b1;

  always_comb begin
    push_item.number    = counter_next;
    push_item.lo        = lo;
    push_item.hi        = hi;
    push_item.malformed = lo > hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (push) begin
      counter <= counter_next;
    end
  end

endmodule

FILE: rtl/core/irt_queue.sv
// Short request queue between the front end and the table engine.
module irt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  irt_pkg::req_t push_item,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output irt_pkg::req_t head_item
);
  import irt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  req_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/irt_back.sv
// Table engine: serial overlap scan over the stored intervals, insert, result register.
module irt_back #(
  parameter int TABLE_DEPTH = irt_pkg::DEFAULT_TABLE_DEPTH,
  parameter int TIME_BITS   = irt_pkg::DEFAULT_TIME_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  irt_pkg::req_t                 q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [irt_pkg::FIELD_BITS-1:0] out_number,
  output logic                          out_granted,
  output irt_pkg::outcome_t             out_outcome
);
  import irt_pkg::*;

  localparam int SB    = (TIME_BITS < FIELD_BITS) ? TIME_BITS : FIELD_BITS;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UW    = $clog2(TABLE_DEPTH + 1);
  localparam logic [UW-1:0] FULL_COUNT = UW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DONE
  } state_t;

  logic [SB-1:0]    mem_start  [TABLE_DEPTH];
  logic [SB-1:0]    mem_finish [TABLE_DEPTH];

  state_t           state;
  logic [UW-1:0]    used;
  logic [IDX_W-1:0] scan_addr;
  logic             issue;
  logic             rd_valid;
  logic             rd_last;
  logic [SB-1:0]    rd_start;
  logic [SB-1:0]    rd_finish;
  outcome_t         res_outcome;

  logic             load;
  logic             wr_en;
  logic             last_issue;
  logic             conflict;

  assign load       = !out_valid || out_ready;
  assign q_pop      = (state == B_DONE) && load;
  assign wr_en      = q_pop && (res_outcome == OUT_GRANTED);
  assign last_issue = (scan_addr == IDX_W'(used - 1'b1));
  assign conflict   = !((rd_finish < q_item.lo[SB-1:0]) ||
                        (rd_start > q_item.hi[SB-1:0]));

  // Table storage: one read port for the scan, one write port for the insert
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_start  <= mem_start[scan_addr];
      rd_finish <= mem_finish[scan_addr];
    end
    if (wr_en) begin
      mem_start[used[IDX_W-1:0]]  <= q_item.lo[SB-1:0];
      mem_finish[used[IDX_W-1:0]] <= q_item.hi[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      used      <= '0;
      scan_addr <= '0;
      issue     <= 1'b0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            if (q_item.malformed) begin
              res_outcome <= OUT_MALFORMED;
              state       <= B_DONE;
            end else if (used == FULL_COUNT) begin
              res_outcome <= OUT_FULL;
              state       <= B_DONE;
            end else if (used == '0) begin
              res_outcome <= OUT_GRANTED;
              state       <= B_DONE;
            end else begin
              scan_addr <= '0;
              issue     <= 1'b1;
              state     <= B_SCAN;
            end
          end
        end
        B_SCAN: begin
          rd_last <= last_issue;
          if (issue) begin
            scan_addr <= scan_addr + 1'b1;
          end
          if (rd_valid && (conflict || rd_last)) begin
            // stop early on the first clash
            res_outcome <= conflict ? OUT_OVERLAP : OUT_GRANTED;
            issue       <= 1'b0;
            rd_valid    <= 1'b0;
            state       <= B_DONE;
          end else begin
            rd_valid <= issue;
            if (issue && last_issue) begin
              issue <= 1'b0;
            end
          end
        end
        B_DONE: begin
          if (load) begin
            out_number  <= q_item.number;
            out_granted <= (res_outcome == OUT_GRANTED);
            out_outcome <= res_outcome;
            if (res_outcome == OUT_GRANTED) begin
              used <= used + 1'b1;
            end
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= FULL_COUNT)
    else $error("table count above depth");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    (rd_valid || issue) |-> (state == B_SCAN))
    else $error("table read outside scan");

  a_grant_grows: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (used == $past(used) + 1'b1))
    else $error("grant did not add a table entry");

  a_grant_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_granted) |-> (out_outcome == OUT_GRANTED))
    else $error("grant flag and outcome disagree");

  a_no_grant_full: assert property (@(posedge clk) disable iff (rst)
    (used == FULL_COUNT) |-> !wr_en)
    else $error("insert into full table");

endmodule

FILE: verif/tb_interval_reservation_table_top.sv
// Self-checking testbench for the interval reservation table top level.
`timescale 1ns / 100ps

module tb_interval_reservation_table_top;
  import irt_pkg::*;

  localparam int          TABLE_DEPTH   = DEFAULT_TABLE_DEPTH;
  localparam int          RESET_CYCLES  = 8;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          DRAIN_CYCLES  = 80;       // above the worst-case scan
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          DIRECTED_ROWS = 19;
  localparam logic [31:0] TIME_MAX      = 32'hFFFF_FFFF;

  // One answer as it leaves the block
  typedef struct packed {
    logic [31:0] number;
    logic        granted;
    outcome_t    outcome;
  } verdict_t;

  // One directed request; typed rows carry their answer, the rest use the predictor
  typedef struct {
    logic [31:0] lo_time;
    logic [31:0] hi_time;
    bit          typed;
    verdict_t    want;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // [31:0] lo_time, [63:32] hi_time
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [31:0] request_number, [33:32] outcome, [39:34] zero
  logic        m_tuser;   // [0] granted

  // Predictor state: granted intervals in arrival order and the request count
  logic [31:0] booked_start [TABLE_DEPTH];
  logic [31:0] booked_finish [TABLE_DEPTH];
  int unsigned booked_count;
  logic [31:0] request_count;

  verdict_t      awaited_verdicts [$];
  directed_row_t directed_rows [DIRECTED_ROWS];
  int            error_count;
  int            cycle_count;
  int            send_idle_pct;
  int            recv_idle_pct;
  bit            hold_request;
  int            hold_left;

  interval_reservation_table_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%08h, expected 0x%08h", what, got, want);
    error_count++;
  endtask

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] d);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, d};
    return sum[32] ? TIME_MAX : sum[31:0];
  endfunction

  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] d);
    return (d > a) ? 32'd0 : a - d;
  endfunction

  // Closed intervals clash unless one ends strictly before the other begins
  function automatic bit clashes_with_bookings(input logic [31:0] lo, input logic [31:0] hi);
    for (int i = 0; i < booked_count; i++)
      if (!(booked_finish[i] < lo || booked_start[i] > hi)) return 1'b1;
    return 1'b0;
  endfunction

  // Number the request, classify it in priority order and book it if it fits
  function automatic verdict_t predict_verdict(input logic [31:0] lo, input logic [31:0] hi);
    verdict_t v;
    if (request_count != COUNT_MAX) request_count++;
    v.number  = request_count;
    v.granted = 1'b0;
    if (lo > hi) begin
      v.outcome = OUT_MALFORMED;
    end else if (booked_count >= TABLE_DEPTH) begin
      v.outcome = OUT_FULL;
    end else if (clashes_with_bookings(lo, hi)) begin
      v.outcome = OUT_OVERLAP;
    end else begin
      booked_start[booked_count]  = lo;
      booked_finish[booked_count] = hi;
      booked_count++;
      v.granted = 1'b1;
      v.outcome = OUT_GRANTED;
    end
    return v;
  endfunction

  function automatic directed_row_t directed_row(input logic [31:0] t0, input logic [31:0] t1,
                                                 input bit typed, input logic [31:0] number,
                                                 input logic granted, input outcome_t outcome);
    directed_row_t row;
    row.lo_time       = t0;
    row.hi_time       = t1;
    row.typed         = typed;
    row.want.number   = number;
    row.want.granted  = granted;
    row.want.outcome  = outcome;
    return row;
  endfunction

  // Offer one request after a random gap; hold it until accepted, then predict
  task automatic send_request(input logic [31:0] t0, input logic [31:0] t1,
                              input bit typed, input verdict_t typed_want);
    verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {t1, t0};
    do @(posedge clk); while (!s_tready);
    v = predict_verdict(t0, t1);
    awaited_verdicts.push_back(typed ? typed_want : v);
  endtask

  // Stop offering and wait for every outstanding answer
  task automatic drain_answers();
    s_tvalid <= 1'b0;
    while (awaited_verdicts.size() != 0) @(posedge clk);
  endtask

  // Build one random request, many of them aimed at the edges of booked intervals
  task automatic random_request(output logic [31:0] t0, output logic [31:0] t1);
    int unsigned pick;
    int unsigned idx;
    logic [5:0]  lane;
    logic [31:0] lo_edge;
    logic [31:0] hi_edge;
    logic [31:0] p;
    logic [31:0] reach;
    pick = $urandom_range(99);
    idx  = (booked_count > 0) ? $urandom_range(booked_count - 1) : 0;
    if (booked_count == 0 || pick >= 58) begin
      // unshaped values: covers every bit, about half come out malformed
      t0 = $urandom;
      t1 = $urandom;
    end else if (pick < 4) begin
      // aim for a free 2^26 lane so the table keeps filling up
      lo_edge = 32'd0;
      hi_edge = 32'd0;
      for (int k = 0; k < 8; k++) begin
        lane    = $urandom_range(63);
        lo_edge = {lane, 26'd16};
        hi_edge = {lane, 26'h3FF_FFEF};
        if (!clashes_with_bookings(lo_edge, hi_edge)) break;
      end
      t0 = lo_edge + $urandom_range(32'h000F_FFFF);
      t1 = t0 + $urandom_range(32'h000F_FFFF);
    end else if (pick < 8) begin
      // one unit clear of a booked interval: the strict side of the rule
      if ($urandom_range(1)) begin
        t0 = booked_finish[idx] + 32'd1;
        t1 = sat_add(t0, $urandom_range(3));
      end else begin
        t1 = booked_start[idx] - 32'd1;
        t0 = sat_sub(t1, $urandom_range(3));
      end
    end else if (pick < 28) begin
      // share exactly one endpoint with a booked interval
      if ($urandom_range(1)) begin
        t1 = booked_start[idx];
        t0 = sat_sub(t1, $urandom_range(300));
      end else begin
        t0 = booked_finish[idx];
        t1 = sat_add(t0, $urandom_range(300));
      end
    end else if (pick < 48) begin
      // straddle a point inside a booked interval, sometimes very widely
      p     = $urandom_range(booked_finish[idx], booked_start[idx]);
      reach = ($urandom_range(3) == 0) ? $urandom : $urandom_range(4096);
      t0    = sat_sub(p, $urandom_range(reach));
      t1    = sat_add(p, $urandom_range(reach));
    end else begin
      // start strictly after finish
      t1 = $urandom_range(32'hFFFF_FFFE);
      t0 = $urandom_range(TIME_MAX, t1 + 32'd1);
    end
  endtask

  task automatic run_phase(input int sender_pct, input int receiver_pct, input int items,
                           input bit long_hold);
    logic [31:0] t0;
    logic [31:0] t1;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    // the sender keeps offering during the hold so the queue fills and s_tready drops
    if (long_hold) hold_request = 1'b1;
    for (int n = 0; n < items; n++) begin
      random_request(t0, t1);
      send_request(t0, t1, 1'b0, '0);
    end
    drain_answers();
  endtask

  // Receiver: random back-pressure, plus one long hold when asked
  initial begin
    m_tready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each answer taken with the oldest one awaited
  always @(posedge clk) begin : check_answers
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_verdicts.size() == 0) begin
        report_mismatch("answer with no request pending", m_tdata[31:0], 32'd0);
      end else begin
        want = awaited_verdicts.pop_front();
        if (m_tdata[31:0] !== want.number)
          report_mismatch("request_number", m_tdata[31:0], want.number);
        if (m_tuser !== want.granted)
          report_mismatch("granted", {31'd0, m_tuser}, {31'd0, want.granted});
        if (m_tdata[33:32] !== want.outcome)
          report_mismatch("outcome", {30'd0, m_tdata[33:32]}, {30'd0, want.outcome});
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    error_count   = 0;
    cycle_count   = 0;
    hold_request  = 1'b0;
    booked_count  = 0;
    request_count = '0;
    send_idle_pct = 7;
    recv_idle_pct = 71;

    // Directed requests: first booking, exact repeat, extremes of the time range,
    // touching endpoints on both sides, the one-unit gap, malformed pairs, and a
    // request covering the whole range
    directed_rows[0]  = directed_row(32'h0000_0000, 32'h0000_0000, 1, 32'd1,  1, OUT_GRANTED);
    directed_rows[1]  = directed_row(32'h0000_0000, 32'h0000_0000, 1, 32'd2,  0, OUT_OVERLAP);
    directed_rows[2]  = directed_row(32'hFFFF_FFFF, 32'h0000_0000, 1, 32'd3,  0, OUT_MALFORMED);
    directed_rows[3]  = directed_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd4,  1, OUT_GRANTED);
    directed_rows[4]  = directed_row(32'hFFFF_FFFE, 32'hFFFF_FFFF, 0, 32'd0,  0, OUT_GRANTED);
    directed_rows[5]  = directed_row(32'h0000_0001, 32'h0000_0001, 0, 32'd0,  0, OUT_GRANTED);
    directed_rows[6]  = directed_row(32'h0000_0001, 32'h0000_0005, 0, 32'd0,  0, OUT_GRANTED);
    directed_rows[7]  = directed_row(32'h8000_0000, 32'h8000_00FF, 0, 32'd0,  0, OUT_GRANTED);
    directed_rows[8]  = directed_row(32'h8000_00FF, 32'h8000_0100, 0, 32'd0,  0, OUT_GRANTED);
    directed_rows[9]  = directed_row(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'd0,  0, OUT_GRANTED);
    directed_rows[10] = directed_row(32'h8000_0100, 32'h8000_0100, 0, 32'd0,  0, OUT_GRANTED);
    directed_rows[11] = directed_row(32'h7FFF_FFFE, 32'h7FFF_FFFF, 0, 32'd0,  0, OUT_GRANTED);
    directed_rows[12] = directed_row(32'h0000_0010, 32'hFFFF_FFF0, 0, 32'd0,  0, OUT_GRANTED);
    directed_rows[13] = directed_row(32'h1234_5678, 32'h1234_5677, 1, 32'd14, 0, OUT_MALFORMED);
    directed_rows[14] = directed_row(32'hAAAA_AAAA, 32'hAAAA_AAAA, 0, 32'd0,  0, OUT_GRANTED);
    directed_rows[15] = directed_row(32'h5555_5555, 32'h5555_5555, 0, 32'd0,  0, OUT_GRANTED);
    directed_rows[16] = directed_row(32'h5555_5554, 32'hAAAA_AAAB, 0, 32'd0,  0, OUT_GRANTED);
    directed_rows[17] = directed_row(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1, 32'd18, 0, OUT_MALFORMED);
    directed_rows[18] = directed_row(32'h0000_0000, 32'hFFFF_FFFF, 1, 32'd19, 0, OUT_OVERLAP);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++)
      send_request(directed_rows[r].lo_time, directed_rows[r].hi_time,
                   directed_rows[r].typed, directed_rows[r].want);
    drain_answers();

    // Random traffic: the table fills part way through, after which the
    // full-table answer takes over for well-formed requests
    run_phase(7, 71, 630, 1'b0);
    run_phase(71, 7, 630, 1'b0);
    run_phase(0, 0, 640, 1'b1);

    // let any stray answer surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_verdicts.size() != 0)
      report_mismatch("answers never delivered", awaited_verdicts.size(), 32'd0);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
